@@ design/gpi_pkg.sv @@
// shared types and defaults for the gravity pull integrator
package gpi_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_MDIV,
    ST_MDIV_WAIT,
    ST_MAG,
    ST_XPROD,
    ST_XDIV,
    ST_XDIV_WAIT,
    ST_XTAKE,
    ST_YDIV,
    ST_YDIV_WAIT,
    ST_YTAKE,
    ST_VEL,
    ST_POS,
    ST_FIN
  } state_t;

  // divider operand selection
  typedef enum logic [1:0] {
    DIV_MAG,
    DIV_PX,
    DIV_PY
  } div_sel_t;

  typedef struct packed {
    logic     take_in;
    logic     place;
    logic     take_diff;
    logic     sq_x;
    logic     sq_y;
    logic     sum;
    logic     root_go;
    logic     div_go;
    div_sel_t div_sel;
    logic     take_mag;
    logic     prod_x;
    logic     prod_y;
    logic     take_px;
    logic     take_py;
    logic     upd_vel;
    logic     upd_pos;
    logic     set_coin;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic coin;
    logic root_busy;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

@@ design/gpi_if.sv @@
// valid/ready channel interfaces for input items and results
interface gpi_in_if #(
  parameter int unsigned W = gpi_pkg::WORD_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                func;
  logic signed [W-1:0] body_x;
  logic signed [W-1:0] body_y;
  logic [W-1:0]        body_mass;

  modport source (output valid, func, body_x, body_y, body_mass, input ready);
  modport sink (input valid, func, body_x, body_y, body_mass, output ready);
endinterface

interface gpi_out_if #(
  parameter int unsigned W = gpi_pkg::WORD_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vel_x;
  logic signed [W-1:0] vel_y;
  logic signed [W-1:0] pos_x;
  logic signed [W-1:0] pos_y;
  logic                coincident;
  logic                saturated;

  modport source (output valid, vel_x, vel_y, pos_x, pos_y, coincident, saturated,
                  input ready);
  modport sink (input valid, vel_x, vel_y, pos_x, pos_y, coincident, saturated,
                output ready);
endinterface

@@ design/gpi_sqrt.sv @@
// bit-serial integer square root, one result bit per cycle
module gpi_sqrt #(
  parameter int unsigned RW = gpi_pkg::WORD_BITS_DEF + 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root,
  output logic            busy
);

  localparam int unsigned CNTW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [CNTW-1:0] cnt_r;
  logic [RW+3:0]   trial_rem;
  logic [RW+3:0]   trial;
  logic            fits;

  // next remainder and trial subtrahend
  assign trial_rem = {rem_r, rad_r[2*RW-1 -: 2]};
  assign trial     = {2'b00, root_r, 2'b01};
  assign fits      = (trial_rem >= trial);

  // iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (go) begin
      cnt_r <= CNTW'(RW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // remainder and root
  always_ff @(posedge clk) begin
    if (go) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      rad_r <= {rad_r[2*RW-3:0], 2'b00};
      if (fits) begin
        rem_r  <= (RW+2)'(trial_rem - trial);
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= trial_rem[RW+1:0];
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign busy = (cnt_r != '0);

endmodule

@@ design/gpi_div.sv @@
// restoring divider with a bounded quotient and an overflow flag
module gpi_div #(
  parameter int unsigned NUMW = 2 * gpi_pkg::WORD_BITS_DEF,
  parameter int unsigned DENW = 2 * gpi_pkg::WORD_BITS_DEF + 2,
  parameter int unsigned QB   = gpi_pkg::WORD_BITS_DEF - 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic [QB-1:0]   quo,
  output logic            ovf,
  output logic            busy
);

  localparam int unsigned CNTW = $clog2(QB + 1);
  localparam int unsigned CW   = (NUMW > DENW) ? NUMW : DENW;

  logic [NUMW-1:0] hi;
  logic [DENW-1:0] rem_r;
  logic [DENW-1:0] den_r;
  logic [QB-1:0]   low_r;
  logic [QB-1:0]   q_r;
  logic            ovf_r;
  logic [CNTW-1:0] cnt_r;
  logic [DENW:0]   trial_rem;
  logic            fits;

  // quotient at or above 2^QB shows in the top part alone
  assign hi        = num >> QB;
  assign trial_rem = {rem_r, low_r[QB-1]};
  assign fits      = (trial_rem >= {1'b0, den_r});

  // iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (go) begin
      cnt_r <= CNTW'(QB);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= DENW'(hi);
      den_r <= den;
      low_r <= num[QB-1:0];
      ovf_r <= (CW'(hi) >= CW'(den));
    end else if (cnt_r != '0) begin
      low_r <= {low_r[QB-2:0], 1'b0};
      q_r   <= {q_r[QB-2:0], fits};
      if (fits) begin
        rem_r <= DENW'(trial_rem - {1'b0, den_r});
      end else begin
        rem_r <= trial_rem[DENW-1:0];
      end
    end
  end

  assign quo  = q_r;
  assign ovf  = ovf_r;
  assign busy = (cnt_r != '0);

endmodule

@@ design/gpi_ctrl.sv @@
// sequencing state machine for place and pull items
module gpi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  output gpi_pkg::cmd_t     cmd,
  input  gpi_pkg::status_t  st
);

  gpi_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gpi_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_func ? gpi_pkg::ST_FIN : gpi_pkg::ST_DIFF;
        end
      end
      gpi_pkg::ST_DIFF:      state_nxt = gpi_pkg::ST_SQX;
      gpi_pkg::ST_SQX:       state_nxt = st.coin ? gpi_pkg::ST_FIN : gpi_pkg::ST_SQY;
      gpi_pkg::ST_SQY:       state_nxt = gpi_pkg::ST_SUM;
      gpi_pkg::ST_SUM:       state_nxt = gpi_pkg::ST_ROOT;
      gpi_pkg::ST_ROOT:      state_nxt = gpi_pkg::ST_ROOT_WAIT;
      gpi_pkg::ST_ROOT_WAIT: begin
        if (!st.root_busy) state_nxt = gpi_pkg::ST_MDIV;
      end
      gpi_pkg::ST_MDIV:      state_nxt = gpi_pkg::ST_MDIV_WAIT;
      gpi_pkg::ST_MDIV_WAIT: begin
        if (!st.div_busy) state_nxt = gpi_pkg::ST_MAG;
      end
      gpi_pkg::ST_MAG:       state_nxt = gpi_pkg::ST_XPROD;
      gpi_pkg::ST_XPROD:     state_nxt = gpi_pkg::ST_XDIV;
      gpi_pkg::ST_XDIV:      state_nxt = gpi_pkg::ST_XDIV_WAIT;
      gpi_pkg::ST_XDIV_WAIT: begin
        if (!st.div_busy) state_nxt = gpi_pkg::ST_XTAKE;
      end
      gpi_pkg::ST_XTAKE:     state_nxt = gpi_pkg::ST_YDIV;
      gpi_pkg::ST_YDIV:      state_nxt = gpi_pkg::ST_YDIV_WAIT;
      gpi_pkg::ST_YDIV_WAIT: begin
        if (!st.div_busy) state_nxt = gpi_pkg::ST_YTAKE;
      end
      gpi_pkg::ST_YTAKE:     state_nxt = gpi_pkg::ST_VEL;
      gpi_pkg::ST_VEL:       state_nxt = gpi_pkg::ST_POS;
      gpi_pkg::ST_POS:       state_nxt = gpi_pkg::ST_FIN;
      gpi_pkg::ST_FIN: begin
        if (st.out_free) state_nxt = gpi_pkg::ST_IDLE;
      end
      default:               state_nxt = gpi_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      gpi_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
        cmd.place   = in_valid & in_func;
      end
      gpi_pkg::ST_DIFF: cmd.take_diff = 1'b1;
      gpi_pkg::ST_SQX: begin
        cmd.set_coin = st.coin;
        cmd.sq_x     = ~st.coin;
      end
      gpi_pkg::ST_SQY:  cmd.sq_y    = 1'b1;
      gpi_pkg::ST_SUM:  cmd.sum     = 1'b1;
      gpi_pkg::ST_ROOT: cmd.root_go = 1'b1;
      gpi_pkg::ST_MDIV: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = gpi_pkg::DIV_MAG;
      end
      gpi_pkg::ST_MAG:   cmd.take_mag = 1'b1;
      gpi_pkg::ST_XPROD: cmd.prod_x   = 1'b1;
      gpi_pkg::ST_XDIV: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = gpi_pkg::DIV_PX;
      end
      gpi_pkg::ST_XTAKE: begin
        cmd.take_px = 1'b1;
        cmd.prod_y  = 1'b1;
      end
      gpi_pkg::ST_YDIV: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = gpi_pkg::DIV_PY;
      end
      gpi_pkg::ST_YTAKE: cmd.take_py  = 1'b1;
      gpi_pkg::ST_VEL:   cmd.upd_vel  = 1'b1;
      gpi_pkg::ST_POS:   cmd.upd_pos  = 1'b1;
      gpi_pkg::ST_FIN:   cmd.load_out = st.out_free;
      default: ;
    endcase
  end

endmodule

@@ design/gpi_dp.sv @@
// datapath: particle state, distance, pull magnitude and output register
module gpi_dp #(
  parameter int unsigned W = gpi_pkg::WORD_BITS_DEF,
  parameter int unsigned F = gpi_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gpi_pkg::cmd_t       cmd,
  output gpi_pkg::status_t    st,
  input  logic signed [W-1:0] in_body_x,
  input  logic signed [W-1:0] in_body_y,
  input  logic [W-1:0]        in_body_mass,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_vel_x,
  output logic signed [W-1:0] out_vel_y,
  output logic signed [W-1:0] out_pos_x,
  output logic signed [W-1:0] out_pos_y,
  output logic                out_coincident,
  output logic                out_saturated
);

  localparam int unsigned DW   = W + 1;
  localparam int unsigned SW   = 2 * DW;
  localparam int unsigned QB   = W - 1;
  localparam int unsigned MW   = W + 2 * F;
  localparam int unsigned PW   = QB + DW;
  localparam int unsigned NUMW = (MW > PW) ? MW : PW;
  localparam int unsigned RWD  = DW;

  // clip a one-bit-wider sum to the word range, flag in the top bit
  function automatic logic [W:0] sat_fn(input logic [W:0] v);
    logic [W:0] r;
    if (v[W] != v[W-1]) begin
      r = {1'b1, v[W], {(W-1){~v[W]}}};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  logic [W-1:0]    bx_r, by_r, mass_r;
  logic [W-1:0]    pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  logic [DW-1:0]   dx_r, dy_r;
  logic [SW-1:0]   sqx_r, sqy_r, s_r;
  logic [QB-1:0]   mag_r, px_r, py_r;
  logic [PW-1:0]   prod_r;
  logic            coin_r, sat_r;
  logic            out_valid_r;
  logic [W-1:0]    out_vel_x_r, out_vel_y_r, out_pos_x_r, out_pos_y_r;
  logic            out_coin_r, out_sat_r;

  logic [DW-1:0]   adx, ady, mul_op, pxe, pye;
  logic [SW-1:0]   sq_w;
  logic [PW-1:0]   prod_w;
  logic [RWD-1:0]  root;
  logic            root_busy;
  logic [NUMW-1:0] div_num;
  logic [SW-1:0]   div_den;
  logic [QB-1:0]   quo;
  logic            div_ovf, div_busy;
  logic [W:0]      vsx, vsy, psx, psy;

  // magnitudes of the differences
  assign adx = dx_r[DW-1] ? (~dx_r + 1'b1) : dx_r;
  assign ady = dy_r[DW-1] ? (~dy_r + 1'b1) : dy_r;

  // one squarer shared by x and y
  assign sq_w   = (cmd.sq_y ? ady : adx) * (cmd.sq_y ? ady : adx);
  assign mul_op = cmd.prod_y ? ady : adx;
  assign prod_w = mag_r * mul_op;

  // divider operand selection
  always_comb begin
    unique case (cmd.div_sel)
      gpi_pkg::DIV_MAG: begin
        div_num = NUMW'({mass_r, {(2*F){1'b0}}});
        div_den = s_r;
      end
      gpi_pkg::DIV_PX, gpi_pkg::DIV_PY: begin
        div_num = NUMW'(prod_r);
        div_den = SW'(root);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  gpi_sqrt #(.RW(RWD)) u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.root_go),
    .rad  (s_r),
    .root (root),
    .busy (root_busy)
  );

  gpi_div #(.NUMW(NUMW), .DENW(SW), .QB(QB)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.div_go),
    .num  (div_num),
    .den  (div_den),
    .quo  (quo),
    .ovf  (div_ovf),
    .busy (div_busy)
  );

  // signed pulls and saturating sums
  assign pxe = dx_r[DW-1] ? (~{2'b00, px_r} + 1'b1) : {2'b00, px_r};
  assign pye = dy_r[DW-1] ? (~{2'b00, py_r} + 1'b1) : {2'b00, py_r};
  assign vsx = sat_fn({vel_x_r[W-1], vel_x_r} + pxe);
  assign vsy = sat_fn({vel_y_r[W-1], vel_y_r} + pye);
  assign psx = sat_fn({pos_x_r[W-1], pos_x_r} + {vel_x_r[W-1], vel_x_r});
  assign psy = sat_fn({pos_y_r[W-1], pos_y_r} + {vel_y_r[W-1], vel_y_r});

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      bx_r   <= in_body_x;
      by_r   <= in_body_y;
      mass_r <= in_body_mass;
    end
    if (cmd.take_diff) begin
      dx_r <= {bx_r[W-1], bx_r} - {pos_x_r[W-1], pos_x_r};
      dy_r <= {by_r[W-1], by_r} - {pos_y_r[W-1], pos_y_r};
    end
    if (cmd.sq_x) sqx_r <= sq_w;
    if (cmd.sq_y) sqy_r <= sq_w;
    if (cmd.sum) s_r <= sqx_r + sqy_r;
    if (cmd.take_mag) mag_r <= div_ovf ? {QB{1'b1}} : quo;
    if (cmd.prod_x || cmd.prod_y) prod_r <= prod_w;
    if (cmd.take_px) px_r <= quo;
    if (cmd.take_py) py_r <= quo;
  end

  // particle state and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      vel_x_r <= '0;
      vel_y_r <= '0;
      coin_r  <= 1'b0;
      sat_r   <= 1'b0;
    end else begin
      if (cmd.take_in) begin
        coin_r <= 1'b0;
        sat_r  <= 1'b0;
      end
      if (cmd.place) begin
        pos_x_r <= in_body_x;
        pos_y_r <= in_body_y;
      end
      if (cmd.set_coin) coin_r <= 1'b1;
      if (cmd.take_mag && div_ovf) sat_r <= 1'b1;
      if (cmd.upd_vel) begin
        vel_x_r <= vsx[W-1:0];
        vel_y_r <= vsy[W-1:0];
        if (vsx[W] || vsy[W]) sat_r <= 1'b1;
      end
      if (cmd.upd_pos) begin
        pos_x_r <= psx[W-1:0];
        pos_y_r <= psy[W-1:0];
        if (psx[W] || psy[W]) sat_r <= 1'b1;
      end
    end
  end

  // result register, freed on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_vel_x_r <= vel_x_r;
      out_vel_y_r <= vel_y_r;
      out_pos_x_r <= pos_x_r;
      out_pos_y_r <= pos_y_r;
      out_coin_r  <= coin_r;
      out_sat_r   <= sat_r;
    end
  end

  assign st.coin      = (dx_r == '0) && (dy_r == '0);
  assign st.root_busy = root_busy;
  assign st.div_busy  = div_busy;
  assign st.out_free  = ~out_valid_r | out_ready;

  assign out_valid      = out_valid_r;
  assign out_vel_x      = out_vel_x_r;
  assign out_vel_y      = out_vel_y_r;
  assign out_pos_x      = out_pos_x_r;
  assign out_pos_y      = out_pos_y_r;
  assign out_coincident = out_coin_r;
  assign out_saturated  = out_sat_r;

endmodule

@@ design/gravity_pull_integrator_top.sv @@
// top level of the gravity pull integrator
// Holds one particle's position and velocity in signed fixed point and
// applies a pull from another body with an Euler step, or places it.
// in_ch: one transfer per item (func, body_x, body_y, body_mass).
// out_ch: one transfer per item with velocity, position and the
//   coincident and saturated flags after that item.
// One item is worked on at a time; in_ch.ready is high only while idle.
// A place item goes from the transfer straight to loading the result.
// Coincident bodies leave the state unchanged.
// A pull waits on the bit-serial square root and then on three passes
//   of the shared restoring divider (magnitude, then x, then y pull).
// The result sits in an output register; the next item is taken while
//   it waits, and a pull only stalls at its end if that register is
//   still full when its own result is ready.
// Reset (synchronous, active low) clears position, velocity and the
//   result valid, and returns the controller to idle.
module gravity_pull_integrator_top #(
  parameter int unsigned WORD_BITS = gpi_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = gpi_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  gpi_in_if.sink    in_ch,
  gpi_out_if.source out_ch
);

  gpi_pkg::cmd_t    cmd;
  gpi_pkg::status_t st;

  gpi_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_func (in_ch.func),
    .in_ready(in_ch.ready),
    .cmd     (cmd),
    .st      (st)
  );

  gpi_dp #(.W(WORD_BITS), .F(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_body_x     (in_ch.body_x),
    .in_body_y     (in_ch.body_y),
    .in_body_mass  (in_ch.body_mass),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_vel_x     (out_ch.vel_x),
    .out_vel_y     (out_ch.vel_y),
    .out_pos_x     (out_ch.pos_x),
    .out_pos_y     (out_ch.pos_y),
    .out_coincident(out_ch.coincident),
    .out_saturated (out_ch.saturated)
  );

`ifndef SYNTHESIS
  // no second item while one is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while busy");

  // result register only loaded when free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> st.out_free)
    else $error("result overwritten");

  // iterative units never started while one is running
  a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_go || cmd.root_go |-> !st.div_busy && !st.root_busy)
    else $error("unit started while busy");

  // a new result always comes from a load
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.load_out))
    else $error("result without load");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the gravity pull integrator
`timescale 1ns / 100ps

module tb_top;

  localparam int W = gpi_pkg::WORD_BITS_DEF;
  localparam int F = gpi_pkg::FRAC_BITS_DEF;
  localparam longint WMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint WMIN = -(64'sd1 <<< (W - 1));
  localparam int N_RAND = 2000;
  localparam int STALL_LIMIT = 5000;

  typedef enum logic {FN_PULL = 1'b0, FN_PLACE = 1'b1} func_t;

  typedef struct {
    logic                func;
    logic signed [W-1:0] bx;
    logic signed [W-1:0] by;
    logic [W-1:0]        mass;
  } body_item_t;

  typedef struct {
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
    logic                coin;
    logic                satf;
  } particle_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gpi_in_if #(.W(W)) in_ch ();
  gpi_out_if #(.W(W)) out_ch ();

  gravity_pull_integrator_top #(.WORD_BITS(W), .FRAC_BITS(F)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  body_item_t pending_bodies[$];
  particle_t  expected_states[$];
  longint st_px, st_py, st_vx, st_vy;
  int items_taken, item_total, mismatches, idle_cycles;

  // clip to the signed word range
  function automatic longint clip(longint v, inout bit flag);
    if (v > WMAX) begin
      flag = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      flag = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  // pull of magnitude mag along one axis over distance d
  function automatic longint axis_pull(longint mag, longint dv, logic [127:0] d);
    logic [127:0] q;
    logic [127:0] a;
    a = (dv < 0) ? 128'(-dv) : 128'(dv);
    q = (128'(mag) * a) / d;
    return (dv < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // euler step or place of the tracked particle for one transfer
  function automatic particle_t step_particle(body_item_t it);
    particle_t r;
    longint dx, dy, mag, ax, ay;
    logic [127:0] s, q, c, d;
    bit coin, satf;
    coin = 1'b0;
    satf = 1'b0;
    if (it.func == FN_PLACE) begin
      st_px = longint'(it.bx);
      st_py = longint'(it.by);
    end else begin
      dx = longint'(it.bx) - st_px;
      dy = longint'(it.by) - st_py;
      if (dx == 0 && dy == 0) begin
        coin = 1'b1;
      end else begin
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        s = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        // bit-serial integer square root
        d = '0;
        for (int b = 63; b >= 0; b--) begin
          c = d | (128'd1 << b);
          if (c * c <= s) d = c;
        end
        q = (128'(it.mass) << (2 * F)) / s;
        if (q > 128'(WMAX)) begin
          mag = WMAX;
          satf = 1'b1;
        end else begin
          mag = longint'(q[63:0]);
        end
        st_vx = clip(st_vx + axis_pull(mag, dx, d), satf);
        st_vy = clip(st_vy + axis_pull(mag, dy, d), satf);
        st_px = clip(st_px + st_vx, satf);
        st_py = clip(st_py + st_vy, satf);
      end
    end
    r.vx = st_vx[W-1:0];
    r.vy = st_vy[W-1:0];
    r.px = st_px[W-1:0];
    r.py = st_py[W-1:0];
    r.coin = coin;
    r.satf = satf;
    return r;
  endfunction

  // idle percentage per phase: sender first busy, then receiver, then none
  function automatic int sender_idle();
    if (items_taken < item_total / 3) return 35;
    if (items_taken < 2 * item_total / 3) return 85;
    return 0;
  endfunction

  function automatic int receiver_idle();
    if (items_taken < item_total / 3) return 85;
    if (items_taken < 2 * item_total / 3) return 35;
    return 0;
  endfunction

  function automatic body_item_t mk(logic fn, logic [W-1:0] x, logic [W-1:0] y,
                                    logic [W-1:0] m);
    body_item_t it;
    it.func = fn;
    it.bx = x;
    it.by = y;
    it.mass = m;
    return it;
  endfunction

  function automatic logic [W-1:0] near_coord(int span_bits);
    return W'($signed($urandom) >>> (W - span_bits));
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_states.push_back(step_particle(pending_bodies.pop_front()));
        items_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bodies.size() > 0 && $urandom_range(99) >= sender_idle()) begin
          in_ch.valid     <= 1'b1;
          in_ch.func      <= pending_bodies[0].func;
          in_ch.body_x    <= pending_bodies[0].bx;
          in_ch.body_y    <= pending_bodies[0].by;
          in_ch.body_mass <= pending_bodies[0].mass;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    particle_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_states.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at %0t", $time);
        end else begin
          e = expected_states.pop_front();
          if (out_ch.vel_x !== e.vx || out_ch.vel_y !== e.vy || out_ch.pos_x !== e.px ||
              out_ch.pos_y !== e.py || out_ch.coincident !== e.coin ||
              out_ch.saturated !== e.satf) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: exp v=(%0d,%0d) p=(%0d,%0d) c=%0b s=%0b",
                       $time, e.vx, e.vy, e.px, e.py, e.coin, e.satf);
              $display("  got v=(%0d,%0d) p=(%0d,%0d) c=%0b s=%0b",
                       out_ch.vel_x, out_ch.vel_y, out_ch.pos_x, out_ch.pos_y,
                       out_ch.coincident, out_ch.saturated);
            end
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= receiver_idle());
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    in_ch.valid = 1'b0;
    in_ch.func = FN_PULL;
    in_ch.body_x = '0;
    in_ch.body_y = '0;
    in_ch.body_mass = '0;
    out_ch.ready = 1'b0;
    items_taken = 0;
    mismatches = 0;
    idle_cycles = 0;
    st_px = 0;
    st_py = 0;
    st_vx = 0;
    st_vy = 0;

    // directed: coincident at reset, zero mass, huge pull, extremes
    pending_bodies.push_back(mk(FN_PULL, 0, 0, 32'h0001_0000));
    pending_bodies.push_back(mk(FN_PULL, 32'h0001_0000, 0, 0));
    pending_bodies.push_back(mk(FN_PLACE, 0, 0, 32'hffff_ffff));
    pending_bodies.push_back(mk(FN_PULL, 32'h0000_0100, 32'hffff_ff00, 32'h0000_0100));
    pending_bodies.push_back(mk(FN_PLACE, 0, 0, 0));
    pending_bodies.push_back(mk(FN_PULL, 1, 0, 32'hffff_ffff));
    pending_bodies.push_back(mk(FN_PULL, 1, 1, 32'hffff_ffff));
    pending_bodies.push_back(mk(FN_PLACE, 32'h7fff_ffff, 32'h7fff_ffff, 0));
    pending_bodies.push_back(mk(FN_PULL, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff));
    pending_bodies.push_back(mk(FN_PULL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h5555_aaaa));
    pending_bodies.push_back(mk(FN_PLACE, 32'h8000_0000, 32'h7fff_ffff, 0));
    pending_bodies.push_back(mk(FN_PULL, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
    pending_bodies.push_back(mk(FN_PLACE, 32'h8000_0000, 32'h8000_0000, 0));
    pending_bodies.push_back(mk(FN_PULL, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678));
    pending_bodies.push_back(mk(FN_PULL, 32'h8000_0001, 32'h8000_0000, 32'h0000_0001));
    pending_bodies.push_back(mk(FN_PLACE, 32'h0010_0000, 32'hfff0_0000, 0));
    pending_bodies.push_back(mk(FN_PULL, 32'hfff0_0000, 32'h0010_0000, 32'h0100_0000));
    pending_bodies.push_back(mk(FN_PULL, 32'h0000_8000, 32'h0000_8000, 32'haaaa_5555));

    // random: mostly nearby pulls, some places, coincident pairs, full-range noise
    for (int i = 0; i < N_RAND; i++) begin
      r = $urandom_range(99);
      if (r < 15) begin
        pending_bodies.push_back(mk(FN_PLACE, near_coord($urandom_range(8, 24)),
                                    near_coord($urandom_range(8, 24)), $urandom));
      end else if (r < 20) begin
        body_item_t p;
        p = mk(FN_PLACE, near_coord(20), near_coord(20), $urandom);
        pending_bodies.push_back(p);
        pending_bodies.push_back(mk(FN_PULL, p.bx, p.by, $urandom));
        i++;
      end else if (r < 28) begin
        pending_bodies.push_back(mk(1'($urandom_range(1)), $urandom, $urandom, $urandom));
      end else begin
        pending_bodies.push_back(mk(FN_PULL, near_coord($urandom_range(12, 26)),
                                    near_coord($urandom_range(12, 26)),
                                    $urandom >> $urandom_range(0, 31)));
      end
    end
    item_total = pending_bodies.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_bodies.size() == 0 && !in_ch.valid && expected_states.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_states.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/gpi_pkg.sv
design/gpi_if.sv
design/gpi_sqrt.sv
design/gpi_div.sv
design/gpi_ctrl.sv
design/gpi_dp.sv
design/gravity_pull_integrator_top.sv
tb/sv/tb_top.sv
